[hw/rtl/btlv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

	// Format limits of the parser.
	localparam int TAG_MAX_BYTES      = 4;
	localparam int MAX_DEPTH          = 8;
	localparam int LENGTH_FIELD_BYTES = 4;

	// Derived widths.
	localparam int TAG_CNT_W = $clog2(TAG_MAX_BYTES + 1);
	localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int LEN_CNT_W = $clog2(LENGTH_FIELD_BYTES + 1);

	// Byte patterns of the encoding.
	localparam logic [7:0] TAG_NUM_MASK = 8'h1F;
	localparam logic [7:0] MORE_BIT     = 8'h80;
	localparam logic [7:0] LEN_CNT_MASK = 8'h7F;
	localparam logic [7:0] PAD_BYTE     = 8'h00;
	localparam logic [7:0] INDEF_LEN    = 8'h80;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_TAG       = 3'd0,
		PH_TAG_MORE  = 3'd1,
		PH_LEN_FIRST = 3'd2,
		PH_LEN_MORE  = 3'd3,
		PH_VALUE     = 3'd4
	} phase_t;

	// Classification of each byte.
	typedef enum logic [2:0] {
		KIND_PAD     = 3'd0,
		KIND_TAG     = 3'd1,
		KIND_LEN     = 3'd2,
		KIND_VALUE   = 3'd3,
		KIND_IGNORED = 3'd4
	} kind_t;

	// Error codes.
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TAG_LONG  = 3'd1,
		ERR_CUT_HDR   = 3'd2,
		ERR_INDEF     = 3'd3,
		ERR_LEN_LONG  = 3'd4,
		ERR_OVERRUN   = 3'd5,
		ERR_TOO_DEEP  = 3'd6
	} err_t;

endpackage

`default_nettype wire

[hw/rtl/ber_tlv_stream_parser_core.sv]
// Output: an accepted byte's result is registered in the output register.
// Throughput: one byte per cycle; a byte is taken whenever the output register is
// empty or its result is taken in the same cycle.
// Reset: arst_n clears the parser state and the output valid; the end-position
// stack holds no reset value and is read only below the current nesting level.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_stream_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       kind,
	output logic [7:0]       echo_byte,
	output logic             header_done,
	output logic [31:0]      tag_value,
	output logic [2:0]       tag_bytes,
	output logic [31:0]      decoded_length,
	output logic             is_constructed,
	output logic [3:0]       depth,
	output logic [3:0]       levels_closed,
	output logic [2:0]       error_code,
	output logic             stream_done
);

	localparam int LVL_W     = btlv_pkg::LVL_W;
	localparam int IDX_W     = btlv_pkg::IDX_W;
	localparam int TAG_CNT_W = btlv_pkg::TAG_CNT_W;
	localparam int LEN_CNT_W = btlv_pkg::LEN_CNT_W;
	localparam int MAX_DEPTH = btlv_pkg::MAX_DEPTH;

	// Parser state.
	btlv_pkg::phase_t       phase_q;
	logic [31:0]            tag_shift_q;
	logic [TAG_CNT_W-1:0]   tag_count_q;
	logic                   first_cons_q;
	logic [31:0]            length_accum_q;
	logic [LEN_CNT_W-1:0]   length_left_q;
	logic [31:0]            value_left_q;
	logic [31:0]            pos_q;
	logic [31:0]            stack_q [MAX_DEPTH];
	logic [LVL_W-1:0]       level_q;
	btlv_pkg::err_t         err_q;

	// Next state.
	btlv_pkg::phase_t       phase_c;
	logic [31:0]            tag_shift_c;
	logic [TAG_CNT_W-1:0]   tag_count_c;
	logic                   first_cons_c;
	logic [31:0]            length_accum_c;
	logic [LEN_CNT_W-1:0]   length_left_c;
	logic [31:0]            value_left_c;
	logic [LVL_W-1:0]       level_c;
	logic [31:0]            stack_c [MAX_DEPTH];
	logic                   push_c;

	// Result of the current byte.
	btlv_pkg::kind_t        kind_c;
	logic                   hdr_c;
	logic [31:0]            tagv_c;
	logic [2:0]             tagb_c;
	logic [31:0]            len_c;
	logic                   cons_c;
	logic [LVL_W-1:0]       closed_c;
	btlv_pkg::err_t         err_c;
	btlv_pkg::err_t         err_out_c;

	// Header completion helpers.
	logic                   fin_c;
	logic [31:0]            fin_len;
	logic [32:0]            pos_p1;
	logic [32:0]            fin_end;
	logic [LVL_W-1:0]       lvl_dec;
	logic [IDX_W-1:0]       top_idx;
	logic [IDX_W-1:0]       push_idx;
	logic                   fin_over;
	logic [LVL_W-1:0]       run_c;
	logic                   going_c;
	logic [MAX_DEPTH-1:0]   match_c;
	logic [TAG_CNT_W-1:0]   tag_inc;

	// Output register.
	logic                   valid_q;
	btlv_pkg::kind_t        kind_q;
	logic [7:0]             echo_q;
	logic                   hdr_q;
	logic [31:0]            tagv_q;
	logic [2:0]             tagb_q;
	logic [31:0]            len_q;
	logic                   cons_q;
	logic [3:0]             depth_q;
	logic [3:0]             closed_q;
	btlv_pkg::err_t         errout_q;
	logic                   done_q;

	logic                   accept;

	assign item_stall = valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	// Position just past this byte, the header length and the object's end.
	assign pos_p1   = {1'b0, pos_q} + 33'd1;
	assign fin_len  = (phase_q == btlv_pkg::PH_LEN_FIRST) ? {24'd0, data_byte}
	                                                      : {length_accum_q[23:0], data_byte};
	assign fin_end  = pos_p1 + {1'b0, fin_len};
	assign lvl_dec  = level_q - LVL_W'(1);
	assign top_idx  = lvl_dec[IDX_W-1:0];
	assign push_idx = level_q[IDX_W-1:0];
	assign fin_over = fin_end[32] ||
	                  ((level_q != '0) && (fin_end > {1'b0, stack_q[top_idx]}));
	assign tag_inc  = tag_count_q + TAG_CNT_W'(1);

	// Byte decode, header completion, closing of finished objects.
	always_comb begin
		phase_c        = phase_q;
		tag_shift_c    = tag_shift_q;
		tag_count_c    = tag_count_q;
		first_cons_c   = first_cons_q;
		length_accum_c = length_accum_q;
		length_left_c  = length_left_q;
		value_left_c   = value_left_q;
		level_c        = level_q;
		push_c         = 1'b0;
		kind_c         = btlv_pkg::KIND_PAD;
		hdr_c          = 1'b0;
		tagv_c         = '0;
		tagb_c         = '0;
		len_c          = '0;
		cons_c         = 1'b0;
		closed_c       = '0;
		err_c          = btlv_pkg::ERR_NONE;
		err_out_c      = btlv_pkg::ERR_NONE;
		fin_c          = 1'b0;
		run_c          = '0;
		going_c        = 1'b1;

		if (err_q != btlv_pkg::ERR_NONE) begin
			kind_c    = btlv_pkg::KIND_IGNORED;
			err_out_c = err_q;
		end else begin
			// Per-phase handling of the byte.
			case (phase_q)
				btlv_pkg::PH_TAG: begin
					if (data_byte != btlv_pkg::PAD_BYTE) begin
						kind_c       = btlv_pkg::KIND_TAG;
						tag_shift_c  = {24'd0, data_byte};
						tag_count_c  = TAG_CNT_W'(1);
						first_cons_c = data_byte[5];
						if ((data_byte & btlv_pkg::TAG_NUM_MASK) == btlv_pkg::TAG_NUM_MASK) begin
							if (btlv_pkg::TAG_MAX_BYTES <= 1)
								err_c = btlv_pkg::ERR_TAG_LONG;
							else
								phase_c = btlv_pkg::PH_TAG_MORE;
						end else begin
							phase_c = btlv_pkg::PH_LEN_FIRST;
						end
					end
				end
				btlv_pkg::PH_TAG_MORE: begin
					kind_c      = btlv_pkg::KIND_TAG;
					tag_shift_c = {tag_shift_q[23:0], data_byte};
					tag_count_c = tag_inc;
					if ((data_byte & btlv_pkg::MORE_BIT) == 8'd0)
						phase_c = btlv_pkg::PH_LEN_FIRST;
					else if (32'(tag_inc) >= 32'(btlv_pkg::TAG_MAX_BYTES))
						err_c = btlv_pkg::ERR_TAG_LONG;
				end
				btlv_pkg::PH_LEN_FIRST: begin
					kind_c = btlv_pkg::KIND_LEN;
					if (data_byte == btlv_pkg::INDEF_LEN) begin
						err_c = btlv_pkg::ERR_INDEF;
					end else if ((data_byte & btlv_pkg::MORE_BIT) == 8'd0) begin
						fin_c = 1'b1;
					end else if (32'(data_byte & btlv_pkg::LEN_CNT_MASK) >
					             32'(btlv_pkg::LENGTH_FIELD_BYTES)) begin
						err_c = btlv_pkg::ERR_LEN_LONG;
					end else begin
						length_left_c  = LEN_CNT_W'(data_byte & btlv_pkg::LEN_CNT_MASK);
						length_accum_c = '0;
						phase_c        = btlv_pkg::PH_LEN_MORE;
					end
				end
				btlv_pkg::PH_LEN_MORE: begin
					kind_c = btlv_pkg::KIND_LEN;
					if (length_accum_q[31:24] != 8'd0) begin
						err_c = btlv_pkg::ERR_LEN_LONG;
					end else begin
						length_accum_c = fin_len;
						if (length_left_q > LEN_CNT_W'(1) )
							length_left_c = length_left_q - LEN_CNT_W'(1);
						else begin
							length_left_c = '0;
							fin_c         = 1'b1;
						end
					end
				end
				default: begin
					kind_c = btlv_pkg::KIND_VALUE;
					if (value_left_q > 32'd1)
						value_left_c = value_left_q - 32'd1;
					else begin
						value_left_c = '0;
						phase_c      = btlv_pkg::PH_TAG;
					end
				end
			endcase

			// Header complete: check the object's end and open it.
			if (fin_c) begin
				if (fin_over) begin
					err_c = btlv_pkg::ERR_OVERRUN;
				end else if (first_cons_q) begin
					if (32'(level_q) >= 32'(MAX_DEPTH)) begin
						err_c = btlv_pkg::ERR_TOO_DEEP;
					end else begin
						push_c  = 1'b1;
						level_c = level_q + LVL_W'(1);
						phase_c = btlv_pkg::PH_TAG;
					end
				end else if (fin_len == 32'd0) begin
					phase_c = btlv_pkg::PH_TAG;
				end else begin
					value_left_c = fin_len;
					phase_c      = btlv_pkg::PH_VALUE;
				end
				if (err_c == btlv_pkg::ERR_NONE) begin
					hdr_c  = 1'b1;
					tagv_c = tag_shift_q;
					tagb_c = (32'(tag_count_q) > 32'd4) ? 3'd4 : 3'(tag_count_q);
					len_c  = fin_len;
					cons_c = first_cons_q;
				end
			end

			// Count the open objects, from the top, that end at this byte.
			for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
				if (LVL_W'(k) < level_c) begin
					if (going_c && match_c[k])
						run_c = run_c + LVL_W'(1);
					else
						going_c = 1'b0;
				end
			end
			if ((err_c == btlv_pkg::ERR_NONE) && (run_c != '0)) begin
				if (phase_c != btlv_pkg::PH_TAG) begin
					err_c = btlv_pkg::ERR_CUT_HDR;
				end else begin
					level_c  = level_c - run_c;
					closed_c = run_c;
				end
			end

			// End of buffer inside a header or an open object.
			if ((err_c == btlv_pkg::ERR_NONE) && end_of_buffer) begin
				if ((phase_c == btlv_pkg::PH_TAG_MORE) || (phase_c == btlv_pkg::PH_LEN_FIRST) ||
				    (phase_c == btlv_pkg::PH_LEN_MORE))
					err_c = btlv_pkg::ERR_CUT_HDR;
				else if ((phase_c == btlv_pkg::PH_VALUE) || (level_c != '0))
					err_c = btlv_pkg::ERR_OVERRUN;
			end

			// A new error suppresses the header and closing results.
			if (err_c != btlv_pkg::ERR_NONE) begin
				hdr_c    = 1'b0;
				tagv_c   = '0;
				tagb_c   = '0;
				len_c    = '0;
				cons_c   = 1'b0;
				closed_c = '0;
				level_c  = level_q;
			end
			err_out_c = err_c;
		end
	end

	// Stack after a possible push, and its compare against the next position.
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			stack_c[i] = (push_c && (push_idx == IDX_W'(i))) ? fin_end[31:0] : stack_q[i];
			match_c[i] = ({1'b0, stack_c[i]} == pos_p1);
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= btlv_pkg::PH_TAG;
			tag_shift_q    <= '0;
			tag_count_q    <= '0;
			first_cons_q   <= 1'b0;
			length_accum_q <= '0;
			length_left_q  <= '0;
			value_left_q   <= '0;
			pos_q          <= '0;
			level_q        <= '0;
			err_q          <= btlv_pkg::ERR_NONE;
		end else if (accept) begin
			if (end_of_buffer) begin
				phase_q        <= btlv_pkg::PH_TAG;
				tag_shift_q    <= '0;
				tag_count_q    <= '0;
				first_cons_q   <= 1'b0;
				length_accum_q <= '0;
				length_left_q  <= '0;
				value_left_q   <= '0;
				pos_q          <= '0;
				level_q        <= '0;
				err_q          <= btlv_pkg::ERR_NONE;
			end else begin
				pos_q <= pos_q + 32'd1;
				if (err_q == btlv_pkg::ERR_NONE) begin
					phase_q        <= phase_c;
					tag_shift_q    <= tag_shift_c;
					tag_count_q    <= tag_count_c;
					first_cons_q   <= first_cons_c;
					length_accum_q <= length_accum_c;
					length_left_q  <= length_left_c;
					value_left_q   <= value_left_c;
					level_q        <= level_c;
					err_q          <= err_c;
				end
			end
		end
	end

	// End-position stack, written on each push.
	always_ff @(posedge clk) begin
		if (accept && push_c)
			stack_q[push_idx] <= fin_end[31:0];
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (accept)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_c;
			echo_q   <= data_byte;
			hdr_q    <= hdr_c;
			tagv_q   <= tagv_c;
			tagb_q   <= tagb_c;
			len_q    <= len_c;
			cons_q   <= cons_c;
			depth_q  <= 4'(level_q);
			closed_q <= 4'(closed_c);
			errout_q <= err_out_c;
			done_q   <= end_of_buffer;
		end
	end

	assign result_valid   = valid_q;
	assign kind           = kind_q;
	assign echo_byte      = echo_q;
	assign header_done    = hdr_q;
	assign tag_value      = tagv_q;
	assign tag_bytes      = tagb_q;
	assign decoded_length = len_q;
	assign is_constructed = cons_q;
	assign depth          = depth_q;
	assign levels_closed  = closed_q;
	assign error_code     = errout_q;
	assign stream_done    = done_q;

endmodule

`default_nettype wire
